/* rtl/kcl_pkg.sv */
`default_nettype none

package kcl_pkg;

  // Default entry length in keys
  localparam int unsigned CODE_LEN = 4;

  // Field widths
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ATT_W   = 4;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned APB_W   = 32;

  // Register reset values
  localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST  = 4'd3;
  localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 16'd10;

  // Keypad matrix positions with a special meaning
  localparam logic [KEY_W-1:0] KEY_ONE  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_TWO  = 4'd1;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd12;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;

  // Register indexes (word address bit 2)
  typedef enum logic {
    REG_MAX_ATTEMPTS  = 1'b0,
    REG_LOCKOUT_TICKS = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_SET     = 2'd0,
    MODE_CHECK   = 2'd1,
    MODE_CONFIRM = 2'd2,
    MODE_LOCKED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_TAKEN     = 3'd1,
    EV_DELETED   = 3'd2,
    EV_STORED    = 3'd3,
    EV_CORRECT   = 3'd4,
    EV_INCORRECT = 3'd5,
    EV_LOCKED    = 3'd6,
    EV_UNLOCKED  = 3'd7
  } event_e;

  typedef struct packed {
    op_e              opcode;
    logic [KEY_W-1:0] key_pos;
  } item_t;

  typedef struct packed {
    logic [ATT_W-1:0]  max_attempts;
    logic [TICK_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [CNT_W-1:0]  entered_count;
    event_e            event_res;
    logic [ATT_W-1:0]  failed_attempts;
    logic [TICK_W-1:0] lock_remaining;
  } res_t;

endpackage

`default_nettype wire

/* rtl/kcl_regs.sv */
`default_nettype none

module kcl_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [kcl_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kcl_pkg::APB_W-1:0]    pwdata,
  output logic      [kcl_pkg::APB_W-1:0]    prdata,
  output logic                              pready,
  output kcl_pkg::cfg_t                     cfg_o
);
  import kcl_pkg::*;

  logic [ATT_W-1:0]  max_att_q;
  logic [TICK_W-1:0] lock_ticks_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q    <= MAX_ATTEMPTS_RST;
      lock_ticks_q <= LOCKOUT_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_ATTEMPTS:  max_att_q    <= pwdata[ATT_W-1:0];
        REG_LOCKOUT_TICKS: lock_ticks_q <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_MAX_ATTEMPTS:  prdata = {{(APB_W-ATT_W){1'b0}}, max_att_q};
      REG_LOCKOUT_TICKS: prdata = {{(APB_W-TICK_W){1'b0}}, lock_ticks_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.max_attempts  = max_att_q;
  assign cfg_o.lockout_ticks = lock_ticks_q;

endmodule

`default_nettype wire

/* rtl/kcl_core.sv */
`default_nettype none

module kcl_core #(
  parameter int unsigned CodeLen = kcl_pkg::CODE_LEN
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  kcl_pkg::item_t      item_i,
  input  kcl_pkg::cfg_t       cfg_i,
  output kcl_pkg::res_t       res_o
);
  import kcl_pkg::*;

  localparam int unsigned CntW = $clog2(CodeLen + 1);
  localparam int unsigned IdxW = (CodeLen > 1) ? $clog2(CodeLen) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(CodeLen);

  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ATT_W-1:0]  att_q, att_d, att_inc;
  logic [TICK_W-1:0] lock_q, lock_d;
  event_e            ev;

  logic [KEY_W-1:0]  entry_q [CodeLen];
  logic [KEY_W-1:0]  code_q  [CodeLen];
  logic              entry_we, code_we, commit, full, match;
  logic [IdxW-1:0]   wr_idx;
  logic [CntW+2:0]   cnt_ext;

  assign full    = (cnt_q == CntFull);
  assign wr_idx  = cnt_q[IdxW-1:0];
  assign att_inc = att_q + 4'd1;

  // Entry against stored code, all keys in parallel
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CodeLen; i++) begin
      if (entry_q[i] != code_q[i]) match = 1'b0;
    end
  end

  // Next state for one item
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    att_d    = att_q;
    lock_d   = lock_q;
    ev       = EV_NONE;
    entry_we = 1'b0;
    code_we  = 1'b0;
    commit   = 1'b0;
    if (step_i) begin
      if (item_i.opcode == OP_TICK) begin
        if (mode_q == MODE_LOCKED) begin
          if (lock_q <= 16'd1) begin
            lock_d = '0;
            mode_d = MODE_CHECK;
            ev     = EV_UNLOCKED;
          end else begin
            lock_d = lock_q - 16'd1;
          end
        end
      end else begin
        unique case (mode_q) inside
          MODE_SET, MODE_CHECK: begin
            if (item_i.key_pos == KEY_HASH) begin
              commit = full;
            end else if (item_i.key_pos == KEY_STAR) begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CntW'(1);
                ev    = EV_DELETED;
              end
            end else if (cnt_q < CntFull) begin
              entry_we = 1'b1;
              cnt_d    = cnt_q + CntW'(1);
              ev       = EV_TAKEN;
            end
          end
          MODE_CONFIRM: begin
            if (item_i.key_pos == KEY_ONE) begin
              cnt_d  = '0;
              mode_d = MODE_SET;
            end else if (item_i.key_pos == KEY_TWO) begin
              cnt_d  = '0;
              mode_d = MODE_CHECK;
            end
          end
          MODE_LOCKED: ;
          default: ;
        endcase

        // Full entry committed by hash
        if (commit) begin
          cnt_d = '0;
          if (mode_q == MODE_SET) begin
            code_we = 1'b1;
            mode_d  = MODE_CHECK;
            ev      = EV_STORED;
          end else if (match) begin
            att_d  = '0;
            mode_d = MODE_CONFIRM;
            ev     = EV_CORRECT;
          end else if (att_inc >= cfg_i.max_attempts) begin
            att_d  = '0;
            mode_d = MODE_LOCKED;
            lock_d = cfg_i.lockout_ticks;
            ev     = EV_LOCKED;
          end else begin
            att_d = att_inc;
            ev    = EV_INCORRECT;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SET;
      cnt_q  <= '0;
      att_q  <= '0;
      lock_q <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      att_q  <= att_d;
      lock_q <= lock_d;
    end
  end

  // Entry buffer and stored code, no reset
  always_ff @(posedge clk_i) begin
    if (entry_we) entry_q[wr_idx] <= item_i.key_pos;
    if (code_we) begin
      for (int i = 0; i < CodeLen; i++) code_q[i] <= entry_q[i];
    end
  end

  // Result reflects the state after the item
  assign cnt_ext = {3'b000, cnt_d};

  assign res_o.mode            = mode_d;
  assign res_o.entered_count   = cnt_ext[CNT_W-1:0];
  assign res_o.event_res       = ev;
  assign res_o.failed_attempts = att_d;
  assign res_o.lock_remaining  = lock_d;

`ifndef SYNTHESIS
  a_lock_only_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_q != '0) |-> (mode_q == MODE_LOCKED))
    else $error("lockout counter running outside locked mode");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count beyond code length");

  a_locked_keys_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.opcode == OP_KEY && mode_q == MODE_LOCKED)
      |=> ($stable(cnt_q) && $stable(lock_q) && mode_q == MODE_LOCKED))
    else $error("key changed state while locked");

  a_correct_confirms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev == EV_CORRECT) |=> (mode_q == MODE_CONFIRM && att_q == '0 && cnt_q == '0))
    else $error("correct code did not reach confirm mode");
`endif

endmodule

`default_nettype wire

/* rtl/keypad_code_lock.sv */
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: key_pos; tuser: opcode
// m_*      out  m_tvalid/m_tready  tdata: mode, entered_count, event_res,
//                                  failed_attempts, lock_remaining
// APB      in   psel/penable       max_attempts @0x0, lockout_ticks @0x4
//
// One item per cycle sustained while m_tready stays high; each item's result
// goes from the input register through the update logic into the result reg
// and is then shown on m_tdata with m_tvalid.
// All state is updated in that single pass, so back-to-back items see the
// state left by the previous one.
// rst_ni clears mode (set), entry count, attempts and lockout counter; the
// entry buffer and stored code are not reset.
// A stalled m_tready holds the result; the input register still takes one
// more item only if it was empty, then s_tready drops.
`default_nettype none

module keypad_code_lock #(
  parameter int unsigned CodeLen = kcl_pkg::CODE_LEN
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // key_pos [3:0], zeros [7:4]
  input  wire logic [7:0]                  s_tdata,
  // opcode [0]
  input  wire logic                        s_tuser,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // mode [1:0], entered_count [4:2], event_res [7:5],
  // failed_attempts [11:8], lock_remaining [27:12], zeros [31:28]
  output logic [31:0]                      m_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kcl_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [kcl_pkg::APB_W-1:0]   pwdata,
  output logic      [kcl_pkg::APB_W-1:0]   prdata,
  output logic                             pready
);
  import kcl_pkg::*;

  logic  in_vld_q, out_vld_q, advance, step;
  item_t in_item_q;
  cfg_t  cfg;
  res_t  res, res_q;

  assign advance  = !out_vld_q || m_tready;
  assign s_tready = !in_vld_q || advance;
  assign step     = in_vld_q && advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_item_q.opcode  <= op_e'(s_tuser);
      in_item_q.key_pos <= s_tdata[KEY_W-1:0];
    end
  end

  kcl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kcl_core #(
    .CodeLen (CodeLen)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {4'b0000, res_q.lock_remaining, res_q.failed_attempts,
                     res_q.event_res, res_q.entered_count, res_q.mode};

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import kcl_pkg::*;

  typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_t;

  localparam int unsigned STALL_LIMIT = 1000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic [7:0]         s_tdata = '0;    // key_pos [3:0], zeros [7:4]
  logic               s_tuser = 1'b0;  // opcode [0]
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        m_tdata;         // mode [1:0], entered_count [4:2], event_res [7:5],
                                       // failed_attempts [11:8], lock_remaining [27:12]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]   pwdata = '0;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  keypad_code_lock dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Lock model state and its copy of the registers
  code_t             saved_code;
  code_t             typed_keys;
  logic [CNT_W-1:0]  typed_n;
  mode_e             lock_state;
  logic [ATT_W-1:0]  miss_count;
  logic [TICK_W-1:0] ticks_left;
  logic [ATT_W-1:0]  limit_misses;
  logic [TICK_W-1:0] lock_len;

  res_t expected_results[$];
  int   mismatches = 0;
  int   useful_items = 0;  // items that raised an event or changed the mode
  bit   steady = 1'b0;     // no idling on either side while set

  // Star, hash and digit handling; returns 1 when a full entry is committed
  function automatic bit edit_keys(logic [KEY_W-1:0] pos, inout event_e ev);
    if (pos == KEY_HASH) return typed_n == CODE_LEN;
    if (pos == KEY_STAR) begin
      if (typed_n != 0) begin
        typed_n--;
        ev = EV_DELETED;
      end
      return 1'b0;
    end
    if (typed_n < CODE_LEN) begin
      typed_keys[typed_n] = pos;
      typed_n++;
      ev = EV_TAKEN;
    end
    return 1'b0;
  endfunction

  // Advance the lock model by one item and return the result it gives
  function automatic res_t lock_step(op_e op, logic [KEY_W-1:0] pos);
    event_e ev;
    mode_e  prev_state;
    res_t   r;
    ev = EV_NONE;
    prev_state = lock_state;
    if (op == OP_TICK) begin
      if (lock_state == MODE_LOCKED) begin
        if (ticks_left <= 16'd1) begin
          ticks_left = '0;
          lock_state = MODE_CHECK;
          ev = EV_UNLOCKED;
        end else begin
          ticks_left--;
        end
      end
    end else begin
      case (lock_state)
        MODE_SET: begin
          if (edit_keys(pos, ev)) begin
            saved_code = typed_keys;
            typed_n = '0;
            lock_state = MODE_CHECK;
            ev = EV_STORED;
          end
        end
        MODE_CHECK: begin
          if (edit_keys(pos, ev)) begin
            typed_n = '0;
            if (typed_keys == saved_code) begin
              miss_count = '0;
              lock_state = MODE_CONFIRM;
              ev = EV_CORRECT;
            end else begin
              miss_count++;
              if (miss_count >= limit_misses) begin
                miss_count = '0;
                lock_state = MODE_LOCKED;
                ticks_left = lock_len;
                ev = EV_LOCKED;
              end else begin
                ev = EV_INCORRECT;
              end
            end
          end
        end
        MODE_CONFIRM: begin
          if (pos == KEY_ONE) begin
            typed_n = '0;
            lock_state = MODE_SET;
          end else if (pos == KEY_TWO) begin
            typed_n = '0;
            lock_state = MODE_CHECK;
          end
        end
        default: ;
      endcase
    end
    if (ev != EV_NONE || lock_state != prev_state) useful_items++;
    r.mode = lock_state;
    r.entered_count = typed_n;
    r.event_res = ev;
    r.failed_attempts = miss_count;
    r.lock_remaining = ticks_left;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_digit();
    logic [KEY_W-1:0] d;
    do d = KEY_W'($urandom_range(15)); while (d == KEY_STAR || d == KEY_HASH);
    return d;
  endfunction

  function automatic code_t random_code();
    code_t c;
    for (int i = 0; i < CODE_LEN; i++) c[i] = pick_digit();
    return c;
  endfunction

  // Send one item with random idle cycles ahead of it, unless steady is set
  task automatic send_item(op_e op, logic [KEY_W-1:0] pos);
    while (!steady && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, pos};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    expected_results.push_back(lock_step(op, pos));
  endtask

  task automatic press(logic [KEY_W-1:0] pos);
    send_item(OP_KEY, pos);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready, then back to idle
  task automatic write_reg(reg_idx_e idx, logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_MAX_ATTEMPTS) limit_misses = value[ATT_W-1:0];
    else lock_len = value[TICK_W-1:0];
  endtask

  // Type a code and commit it, with the odd typo corrected by star
  task automatic enter_code(code_t code, bit clear);
    while (clear && typed_n != 0) press(KEY_STAR);
    for (int i = 0; i < CODE_LEN; i++) begin
      if ($urandom_range(4) == 0 && typed_n < CODE_LEN) begin
        press(pick_digit());
        press(KEY_STAR);
      end
      press(code[i]);
    end
    press(KEY_HASH);
  endtask

  task automatic go_to_check();
    while (lock_state != MODE_CHECK) begin
      case (lock_state)
        MODE_LOCKED:  send_item(OP_TICK, KEY_W'($urandom_range(15)));
        MODE_CONFIRM: press(KEY_TWO);
        default:      enter_code(random_code(), 1'b1);
      endcase
    end
  endtask

  // Set mode edits: empty star, short hash, idle tick, full entry, store
  task automatic test_entry_edits();
    press(KEY_STAR);
    press(KEY_HASH);
    send_item(OP_TICK, 4'hF);
    press(4'd15);
    press(4'd0);
    press(KEY_STAR);
    press(4'd0);
    press(4'd7);
    press(4'd15);
    press(4'd3);
    press(KEY_HASH);
    wait_idle();
  endtask

  // Correct code, ignored key in confirm mode, back to check
  task automatic test_code_check();
    press(4'd15);
    press(4'd0);
    press(4'd7);
    press(4'd15);
    press(KEY_HASH);
    press(4'd9);
    press(KEY_TWO);
    wait_idle();
  endtask

  // Zero attempts locks on the first miss, zero ticks unlocks on one tick
  task automatic test_instant_lock();
    write_reg(REG_MAX_ATTEMPTS, 32'd0);
    write_reg(REG_LOCKOUT_TICKS, 32'd0);
    press(4'd1);
    press(4'd2);
    press(4'd3);
    press(4'd4);
    press(KEY_HASH);
    press(4'd5);
    send_item(OP_TICK, 4'h0);
    wait_idle();
  endtask

  // Mostly well-formed sessions with random content, plus noise
  task automatic random_session(int target);
    int    stop_at;
    int    r;
    code_t code;
    stop_at = useful_items + target;
    while (useful_items < stop_at) begin
      r = $urandom_range(99);
      case (lock_state)
        MODE_LOCKED: begin
          if (r < 90) send_item(OP_TICK, KEY_W'($urandom_range(15)));
          else press(KEY_W'($urandom_range(15)));
        end
        MODE_CONFIRM: begin
          if (r < 40) press(KEY_ONE);
          else if (r < 80) press(KEY_TWO);
          else if (r < 92) press(KEY_W'($urandom_range(15)));
          else send_item(OP_TICK, KEY_W'($urandom_range(15)));
        end
        default: begin
          if (r < 70) begin
            code = random_code();
            if (lock_state == MODE_CHECK && r < 35) begin
              code = saved_code;
            end else if (lock_state == MODE_CHECK && r < 50) begin
              code = saved_code;
              code[$urandom_range(CODE_LEN - 1)] = pick_digit();
            end
            enter_code(code, $urandom_range(4) != 0);
          end else if (r < 90) begin
            press(KEY_W'($urandom_range(15)));
          end else begin
            send_item(OP_TICK, KEY_W'($urandom_range(15)));
          end
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [ATT_W-1:0]  attempts_set[5] = '{4'd1, 4'd15, 4'd2, 4'd7, 4'd3};
    logic [TICK_W-1:0] ticks_set[5]    = '{16'd1, 16'd3, 16'd0, 16'd37, 16'd10};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_MAX_ATTEMPTS, {28'd0, attempts_set[p]});
      write_reg(REG_LOCKOUT_TICKS, {16'd0, ticks_set[p]});
      steady = (p == 1);
      random_session(230);
    end
    steady = 1'b0;
  endtask

  // Misses in a row up to the limit of fifteen attempts, then a 40-tick lockout
  task automatic test_long_lockout();
    code_t wrong;
    write_reg(REG_MAX_ATTEMPTS, 32'd15);
    write_reg(REG_LOCKOUT_TICKS, 32'd40);
    go_to_check();
    while (lock_state != MODE_LOCKED) begin
      wrong = saved_code;
      do wrong[0] = pick_digit(); while (wrong[0] == saved_code[0]);
      enter_code(wrong, 1'b1);
    end
    while (lock_state == MODE_LOCKED) send_item(OP_TICK, KEY_W'($urandom_range(15)));
    enter_code(saved_code, 1'b1);
    wait_idle();
  endtask

  task automatic report_bad(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): exp mode=%0d cnt=%0d ev=%0d fails=%0d left=%0d",
               what, want.mode, want.entered_count, want.event_res,
               want.failed_attempts, want.lock_remaining);
      $display("  got mode=%0d cnt=%0d ev=%0d fails=%0d left=%0d",
               got.mode, got.entered_count, got.event_res,
               got.failed_attempts, got.lock_remaining);
    end
  endtask

  // Result side: random back-pressure (none while steady) and field-by-field checking
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.mode            = mode_e'(m_tdata[1:0]);
      got.entered_count   = m_tdata[4:2];
      got.event_res       = event_e'(m_tdata[7:5]);
      got.failed_attempts = m_tdata[11:8];
      got.lock_remaining  = m_tdata[27:12];
      if (expected_results.size() == 0) begin
        want = '0;
        report_bad("unexpected result", want, got);
      end else begin
        want = expected_results.pop_front();
        if (got.mode !== want.mode || got.entered_count !== want.entered_count ||
            got.event_res !== want.event_res || got.failed_attempts !== want.failed_attempts ||
            got.lock_remaining !== want.lock_remaining)
          report_bad("field differs", want, got);
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 29);
  end

  // Watchdog on cycles without any accepted item or taken result
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    saved_code   = '0;
    typed_keys   = '0;
    typed_n      = '0;
    lock_state   = MODE_SET;
    miss_count   = '0;
    ticks_left   = '0;
    limit_misses = MAX_ATTEMPTS_RST;
    lock_len     = LOCKOUT_TICKS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_entry_edits();
    test_code_check();
    test_instant_lock();
    test_random_phases();
    test_long_lockout();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
